@@ rtl/itoa_pkg.sv @@
// ----------------------------------------------------------------------------
// itoa_pkg
// shared types, constants and helpers for the integer to decimal text block
// ----------------------------------------------------------------------------
`default_nettype none

package itoa_pkg;

    localparam int VALUE_WIDTH_DEF = 32;

    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_LOCATE,
        ST_SIGN,
        ST_DIGITS
    } state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_in;
        logic shift;
        logic locate;
        logic emit_sign;
        logic emit_digit;
    } cmd_t;

    // status from the datapath back to the controller
    typedef struct packed {
        logic bits_done;
        logic negative;
        logic digit_last;
        logic out_free;
    } sts_t;

    // double-dabble correction of one bcd digit ahead of the shift
    function automatic logic [3:0] dd_adjust(input logic [3:0] d);
        logic [3:0] r;
        r = (d >= 4'd5) ? (d + 4'd3) : d;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/itoa_ctrl.sv @@
// ----------------------------------------------------------------------------
// itoa_ctrl
// sequencer: take a word, run the binary to bcd shifts, then send the text
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             value_valid,
    output logic                  value_stall,
    input  wire itoa_pkg::sts_t   sts,
    output itoa_pkg::cmd_t        cmd
);

    itoa_pkg::state_t state_reg;
    itoa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= itoa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        value_stall = 1'b1;
        unique case (state_reg)
            itoa_pkg::ST_IDLE:
            begin
                value_stall = 1'b0;
                if (value_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = itoa_pkg::ST_CONVERT;
                end
            end
            itoa_pkg::ST_CONVERT:
            begin
                cmd.shift = 1'b1;
                if (sts.bits_done)
                begin
                    state_next = itoa_pkg::ST_LOCATE;
                end
            end
            itoa_pkg::ST_LOCATE:
            begin
                cmd.locate = 1'b1;
                state_next = sts.negative ? itoa_pkg::ST_SIGN : itoa_pkg::ST_DIGITS;
            end
            itoa_pkg::ST_SIGN:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = itoa_pkg::ST_DIGITS;
                end
            end
            itoa_pkg::ST_DIGITS:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (sts.digit_last)
                    begin
                        state_next = itoa_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = itoa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/itoa_datapath.sv @@
// ----------------------------------------------------------------------------
// itoa_datapath
// magnitude and bcd shift registers, digit pointer and output word register
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_datapath #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [VALUE_WIDTH-1:0] value,
    input  wire itoa_pkg::cmd_t         cmd,
    output itoa_pkg::sts_t              sts,
    output logic                        text_valid,
    input  wire logic                   text_stall,
    output logic [7:0]                  text_char,
    output logic                        is_last
);

    // decimal digits of 2^(VALUE_WIDTH-1)
    localparam int ND = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
    localparam int BW = ND * 4;
    localparam int CW = $clog2(VALUE_WIDTH);
    localparam int IW = $clog2(ND);

    logic [VALUE_WIDTH-1:0] bin_reg;
    logic [VALUE_WIDTH-1:0] bin_next;
    logic [BW-1:0]          bcd_reg;
    logic [BW-1:0]          bcd_next;
    logic [BW-1:0]          bcd_adj;
    logic [CW-1:0]          cnt_reg;
    logic [CW-1:0]          cnt_next;
    logic [IW-1:0]          idx_reg;
    logic [IW-1:0]          idx_next;
    logic [IW-1:0]          lead;
    logic                   neg_reg;
    logic                   neg_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [7:0]             char_reg;
    logic [7:0]             char_next;
    logic                   last_reg;
    logic                   last_next;
    logic [3:0]             digit;
    logic                   out_free;

    always_comb
    begin
        for (int i = 0; i < ND; i++)
        begin
            bcd_adj[i*4 +: 4] = itoa_pkg::dd_adjust(bcd_reg[i*4 +: 4]);
        end
    end

    // most significant non-zero digit, zero keeps a single digit
    always_comb
    begin
        lead = '0;
        for (int i = 0; i < ND; i++)
        begin
            if (bcd_reg[i*4 +: 4] != 4'd0)
            begin
                lead = IW'(i);
            end
        end
    end

    assign digit    = bcd_reg[{idx_reg, 2'b00} +: 4];
    assign out_free = !out_valid_reg || !text_stall;

    always_comb
    begin
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        neg_next       = neg_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        out_valid_next = text_stall ? out_valid_reg : 1'b0;

        if (cmd.load_in)
        begin
            neg_next = value[VALUE_WIDTH-1];
            bin_next = value[VALUE_WIDTH-1] ? (~value + VALUE_WIDTH'(1)) : value;
            bcd_next = '0;
            cnt_next = '0;
        end
        if (cmd.shift)
        begin
            bcd_next = {bcd_adj[BW-2:0], bin_reg[VALUE_WIDTH-1]};
            bin_next = {bin_reg[VALUE_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg + CW'(1);
        end
        if (cmd.locate)
        begin
            idx_next = lead;
        end
        if (cmd.emit_sign)
        begin
            char_next      = itoa_pkg::CHAR_MINUS;
            last_next      = 1'b0;
            out_valid_next = 1'b1;
        end
        if (cmd.emit_digit)
        begin
            char_next      = itoa_pkg::CHAR_ZERO + {4'd0, digit};
            last_next      = (idx_reg == '0);
            out_valid_next = 1'b1;
            idx_next       = idx_reg - IW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        cnt_reg  <= cnt_next;
        idx_reg  <= idx_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign sts.bits_done  = (cnt_reg == CW'(VALUE_WIDTH - 1));
    assign sts.negative   = neg_reg;
    assign sts.digit_last = (idx_reg == '0);
    assign sts.out_free   = out_free;

    assign text_valid = out_valid_reg;
    assign text_char  = char_reg;
    assign is_last    = last_reg;

endmodule

`default_nettype wire

@@ rtl/int_to_decimal_ascii.sv @@
// an accepted word runs the double-dabble shift loop and the leading-digit search before the first character
// a new word waits until every character of the previous word is issued; each word runs the
// one-bit-per-cycle double-dabble shift loop, then one character per cycle unless stalled
// the output register lets the next word be taken while the last character is stalled
// reset clears the sequencer and the output valid only; payload registers are not reset
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// signed integer to decimal ascii text, most significant character first
// ----------------------------------------------------------------------------
`default_nettype none

module int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   value_valid,
    output logic                        value_stall,
    input  wire logic [VALUE_WIDTH-1:0] value,
    output logic                        text_valid,
    input  wire logic                   text_stall,
    output logic [7:0]                  text_char,
    output logic                        is_last
);

    itoa_pkg::cmd_t cmd;
    itoa_pkg::sts_t sts;

    itoa_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_valid),
        .value_stall (value_stall),
        .sts         (sts),
        .cmd         (cmd)
    );

    itoa_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (value),
        .cmd        (cmd),
        .sts        (sts),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text_char  (text_char),
        .is_last    (is_last)
    );

endmodule

`default_nettype wire
